[rtl/vector_rect_polar_unit_defines.svh]
// Assertion macros shared by the checker of the coordinate unit.
`ifndef VECTOR_RECT_POLAR_UNIT_DEFINES_SVH
`define VECTOR_RECT_POLAR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vrp_pkg.sv]
`default_nettype none
package vrp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    // CORDIC datapath widths: x/y carry 16 guard bits, z is in turns (2^32 = 360 deg)
    localparam int XW = 52;
    localparam int ZW = 34;

    localparam logic [2:0] OP_RECT  = 3'd0;
    localparam logic [2:0] OP_POLAR = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SUB   = 3'd3;
    localparam logic [2:0] OP_NEG   = 3'd4;
    localparam logic [2:0] OP_SCALE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam logic [31:0] GAIN_BASE = 32'd2608131496;
    localparam logic [31:0] GAIN_TAIL = 32'd1738754330;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cvec_t;

    typedef struct packed {
        logic               rot;
        logic               zero;
        logic               sat;
        logic               invalid;
        logic [31:0]        mag;
        logic signed [24:0] deg;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
    } side_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

    function automatic logic signed [24:0] clamp25(input logic signed [40:0] v);
        logic signed [24:0] r;
        if (v > 41'sd16777215)
            r = 25'sh0FFFFFF;
        else if (v < -41'sd16777216)
            r = 25'sh1000000;
        else
            r = 25'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/vrp_cordic_stage.sv]
`default_nettype none
module vrp_cordic_stage
    import vrp_pkg::*;
#(
    parameter int STAGE = 0
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire cvec_t in_vec,
    input  wire side_t in_side,
    output logic       out_valid,
    output cvec_t      out_vec,
    output side_t      out_side
);

    logic                 valid_reg;
    cvec_t                vec_reg;
    side_t                side_reg;
    cvec_t                vec_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;
    logic                 ccw;

    always_comb
    begin
        dx  = in_vec.y >>> STAGE;
        dy  = in_vec.x >>> STAGE;
        da  = signed'(ZW'(atan_turn(5'(STAGE))));
        // rotation follows the residual angle, vectoring drives y to zero
        ccw = in_side.rot ? !in_vec.z[ZW-1] : in_vec.y[XW-1];
        if (ccw)
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - da;
        end
        else
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

[rtl/vrp_prep.sv]
`default_nettype none
module vrp_prep
    import vrp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [2:0]         op,
    input  wire logic signed [31:0] arg_a,
    input  wire logic signed [31:0] arg_b,
    input  wire logic signed [31:0] arg_c,
    input  wire logic signed [31:0] arg_d,
    output logic                    out_valid,
    output cvec_t                   out_vec,
    output side_t                   out_side
);

    localparam logic [39:0] FULL     = 40'd360 << FRAC_BITS;
    localparam logic [39:0] HALF_DEG = 40'd180 << FRAC_BITS;
    localparam logic [39:0] OFFS     = ((40'h80000000 + FULL - 40'd1) / FULL) * FULL;
    localparam logic [63:0] R1_L     = ((64'd1 << 36) + 64'd359) / 64'd360;
    localparam logic [63:0] R2_L     = ((64'd1 << 44) + 64'd44) / 64'd45;
    localparam logic [27:0] R1       = R1_L[27:0];
    localparam logic [38:0] R2       = R2_L[38:0];
    localparam logic signed [ZW-1:0] HALF_T    = ZW'(64'sd2147483648);
    localparam logic signed [32:0]   HALF_T33  = 33'sh080000000;
    localparam logic signed [32:0]   QUARTER_T = 33'sh040000000;

    // stage A: sums, products, angle range reduction product
    logic                valid_a_reg;
    logic [2:0]          op_a_reg;
    logic signed [31:0]  a_a_reg;
    logic signed [32:0]  sx_a_reg, sy_a_reg;
    logic signed [63:0]  px_a_reg, py_a_reg;
    logic [35:0]         u_a_reg;
    logic [53:0]         qp_a_reg;
    logic signed [32:0]  sx_next, sy_next;
    logic [35:0]         v_next, u_next;
    logic [25:0]         w_next;

    always_comb
    begin
        case (op)
            OP_ADD:
            begin
                sx_next = 33'(arg_a) + 33'(arg_c);
                sy_next = 33'(arg_b) + 33'(arg_d);
            end
            OP_SUB:
            begin
                sx_next = 33'(arg_a) - 33'(arg_c);
                sy_next = 33'(arg_b) - 33'(arg_d);
            end
            OP_NEG:
            begin
                sx_next = -33'(arg_a);
                sy_next = -33'(arg_b);
            end
            default:
            begin
                sx_next = 33'(arg_a);
                sy_next = 33'(arg_b);
            end
        endcase
        // negative magnitude turns the direction by half a circle
        v_next = 36'(arg_b) + (arg_a[31] ? 36'(HALF_DEG) : 36'd0);
        u_next = v_next + 36'(OFFS);
        w_next = 26'(u_next >> FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (en)
            valid_a_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg <= op;
            a_a_reg  <= arg_a;
            sx_a_reg <= sx_next;
            sy_a_reg <= sy_next;
            px_a_reg <= 64'(arg_a) * 64'(arg_c);
            py_a_reg <= 64'(arg_b) * 64'(arg_c);
            u_a_reg  <= u_next;
            qp_a_reg <= 54'(w_next) * 54'(R1);
        end
    end

    // stage B: saturate rectangular operands, finish modulo 360
    logic               valid_b_reg;
    side_t              side_b_reg;
    logic [37:0]        mm_b_reg;
    side_t              side_b_next;
    logic [37:0]        mm_b_next;
    logic signed [63:0] rx, ry, xv, yv;
    logic [17:0]        q1;
    logic [39:0]        rr;
    logic signed [40:0] d1;
    logic [47:0]        nn;
    logic [32:0]        am;
    logic               inv_b;
    logic               rot_b;

    always_comb
    begin
        rx = (px_a_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        ry = (py_a_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        xv = (op_a_reg == OP_SCALE) ? rx : 64'(sx_a_reg);
        yv = (op_a_reg == OP_SCALE) ? ry : 64'(sy_a_reg);
        q1 = qp_a_reg[53:36];
        rr = 40'(u_a_reg) - ((40'(q1) * 40'd360) << FRAC_BITS);
        if (rr >= HALF_DEG)
            d1 = $signed({1'b0, rr}) - $signed({1'b0, FULL});
        else
            d1 = $signed({1'b0, rr});
        nn = (48'(rr) << (32 - FRAC_BITS)) + 48'd180;
        am = a_a_reg[31] ? -33'(a_a_reg) : 33'(a_a_reg);
        rot_b = (op_a_reg == OP_POLAR);
        inv_b = (op_a_reg > OP_SCALE);

        side_b_next.rot     = rot_b;
        side_b_next.invalid = inv_b;
        side_b_next.sat     = !rot_b && !inv_b && (ovf32(xv) || ovf32(yv));
        side_b_next.xs      = (rot_b || inv_b) ? 32'sd0 : sat32(xv);
        side_b_next.ys      = (rot_b || inv_b) ? 32'sd0 : sat32(yv);
        side_b_next.mag     = am[31:0];
        side_b_next.deg     = clamp25(d1);
        if (rot_b)
            side_b_next.zero = (a_a_reg == 32'sd0);
        else
            side_b_next.zero = inv_b || ((sat32(xv) == 32'sd0) && (sat32(yv) == 32'sd0));
        mm_b_next = nn[40:3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_b_reg <= 1'b0;
        else if (en)
            valid_b_reg <= valid_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_b_reg <= side_b_next;
            mm_b_reg   <= mm_b_next;
        end
    end

    // stage C: degrees to turns, reciprocal product in two halves
    logic        valid_c_reg;
    side_t       side_c_reg;
    logic [57:0] ph_c_reg, pl_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_c_reg <= 1'b0;
        else if (en)
            valid_c_reg <= valid_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_c_reg <= side_b_reg;
            ph_c_reg   <= 58'(mm_b_reg[37:19]) * 58'(R2);
            pl_c_reg   <= 58'(mm_b_reg[18:0]) * 58'(R2);
        end
    end

    // stage D: quadrant fold and CORDIC seed
    logic                 valid_d_reg;
    side_t                side_d_reg;
    cvec_t                vec_d_reg;
    cvec_t                vec_d_next;
    logic [76:0]          qs;
    logic signed [31:0]   tt;
    logic signed [32:0]   tf;
    logic                 mneg;
    logic signed [XW-1:0] mw;

    always_comb
    begin
        qs = (77'(ph_c_reg) << 19) + 77'(pl_c_reg);
        tt = signed'(qs[75:44]);
        tf = 33'(tt);
        mneg = 1'b0;
        if (33'(tt) > QUARTER_T)
        begin
            tf   = 33'(tt) - HALF_T33;
            mneg = 1'b1;
        end
        else if (33'(tt) < -QUARTER_T)
        begin
            tf   = 33'(tt) + HALF_T33;
            mneg = 1'b1;
        end
        mw = signed'(XW'(side_c_reg.mag) << 16);

        if (side_c_reg.rot)
        begin
            vec_d_next.x = mneg ? -mw : mw;
            vec_d_next.y = '0;
            vec_d_next.z = ZW'(tf);
        end
        else if (side_c_reg.xs[31])
        begin
            vec_d_next.x = -(XW'(side_c_reg.xs) <<< 16);
            vec_d_next.y = -(XW'(side_c_reg.ys) <<< 16);
            vec_d_next.z = side_c_reg.ys[31] ? -HALF_T : HALF_T;
        end
        else
        begin
            vec_d_next.x = XW'(side_c_reg.xs) <<< 16;
            vec_d_next.y = XW'(side_c_reg.ys) <<< 16;
            vec_d_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_d_reg <= 1'b0;
        else if (en)
            valid_d_reg <= valid_c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_d_reg <= side_c_reg;
            vec_d_reg  <= vec_d_next;
        end
    end

    assign out_valid = valid_d_reg;
    assign out_vec   = vec_d_reg;
    assign out_side  = side_d_reg;

endmodule
`default_nettype wire

[rtl/vrp_post.sv]
`default_nettype none
module vrp_post
    import vrp_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         in_valid,
    input  wire cvec_t        in_vec,
    input  wire side_t        in_side,
    output logic              out_valid,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic [31:0]       magnitude,
    output logic signed [24:0] angle_deg,
    output logic [1:0]        status
);

    localparam int          STEPS_EFF = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int          GSH       = 2 * STEPS_EFF;
    localparam logic [31:0] GAIN      = (GSH < 32) ? (GAIN_BASE + (GAIN_TAIL >> GSH))
                                                   : GAIN_BASE;
    localparam logic signed [ZW-1:0] HALF_T = ZW'(64'sd2147483648);
    localparam logic signed [43:0]   LIM    = 44'sd180 <<< FRAC_BITS;

    // stage G1: gain partial products and turns to degrees
    logic               valid_g_reg;
    side_t              side_g_reg;
    logic [51:0]        phx_reg, phy_reg;
    logic [63:0]        plx_reg, ply_reg;
    logic               negx_reg, negy_reg;
    logic signed [24:0] degv_reg;
    logic [XW-1:0]      ux, uy;
    logic signed [ZW-1:0] zc;
    logic signed [43:0] z360, zr;
    logic signed [24:0] degv_next;

    always_comb
    begin
        ux = in_vec.x[XW-1] ? XW'(-in_vec.x) : XW'(in_vec.x);
        uy = in_vec.y[XW-1] ? XW'(-in_vec.y) : XW'(in_vec.y);
        if (in_vec.z > HALF_T)
            zc = HALF_T;
        else if (in_vec.z < -HALF_T)
            zc = -HALF_T;
        else
            zc = in_vec.z;
        z360 = 44'(zc) * 44'sd360;
        zr   = (z360 + (44'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
        if (zr > LIM)
            zr = LIM;
        else if (zr < -LIM)
            zr = -LIM;
        degv_next = clamp25(41'(zr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_g_reg <= 1'b0;
        else if (en)
            valid_g_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_g_reg <= in_side;
            phx_reg    <= 52'(ux[XW-1:32]) * 52'(GAIN);
            phy_reg    <= 52'(uy[XW-1:32]) * 52'(GAIN);
            plx_reg    <= 64'(ux[31:0]) * 64'(GAIN);
            ply_reg    <= 64'(uy[31:0]) * 64'(GAIN);
            negx_reg   <= in_vec.x[XW-1];
            negy_reg   <= in_vec.y[XW-1];
            degv_reg   <= degv_next;
        end
    end

    // stage G2: finish gain, drop guard bits, saturate, pick fields
    logic               valid_o_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [31:0]        mag_reg;
    logic signed [24:0] deg_reg;
    logic [1:0]         status_reg;
    logic [52:0]        mx, my;
    logic signed [53:0] vx, vy, gx, gy;
    logic signed [31:0] x_next, y_next;
    logic [31:0]        mag_next;
    logic signed [24:0] deg_next;
    logic               sat_next;
    logic [1:0]         status_next;

    always_comb
    begin
        mx = 53'(phx_reg) + 53'(plx_reg[63:32]);
        my = 53'(phy_reg) + 53'(ply_reg[63:32]);
        vx = negx_reg ? -signed'(54'(mx)) : signed'(54'(mx));
        vy = negy_reg ? -signed'(54'(my)) : signed'(54'(my));
        gx = (vx + 54'sd32768) >>> 16;
        gy = (vy + 54'sd32768) >>> 16;
        sat_next = side_g_reg.sat;
        if (side_g_reg.rot)
        begin
            x_next   = sat32(64'(gx));
            y_next   = sat32(64'(gy));
            sat_next = ovf32(64'(gx)) || ovf32(64'(gy));
            mag_next = side_g_reg.mag;
            deg_next = side_g_reg.deg;
        end
        else
        begin
            x_next   = side_g_reg.xs;
            y_next   = side_g_reg.ys;
            deg_next = degv_reg;
            if (gx < 54'sd0)
                mag_next = '0;
            else if (gx > 54'sh0FFFFFFFF)
            begin
                mag_next = 32'hFFFFFFFF;
                sat_next = 1'b1;
            end
            else
                mag_next = 32'(gx);
        end
        if (side_g_reg.zero)
        begin
            mag_next = '0;
            deg_next = '0;
        end
        if (side_g_reg.invalid)
            status_next = ST_INVALID;
        else if (sat_next)
            status_next = ST_SAT;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_o_reg <= 1'b0;
        else if (en)
            valid_o_reg <= valid_g_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            mag_reg    <= mag_next;
            deg_reg    <= deg_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_o_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign magnitude = mag_reg;
    assign angle_deg = deg_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

[rtl/vector_rect_polar_unit.sv]
// Coordinate unit for 2-D vectors in signed fixed point (Q16.16 by default).
// Input channel s_axis: tuser carries the op code, tdata the four operands.
//   op 0 rect->polar, 1 polar(degrees)->rect, 2 add, 3 sub, 4 negate, 5 scale.
// Output channel m_axis: every result word carries x, y, magnitude and
//   angle in degrees; tuser carries status (0 ok, 1 bad op, 2 saturated).
// Pipeline: front-end stages A to D, then one CORDIC stage per rotation step,
//   then back-end stages G1 and G2.
// Throughput: one word per cycle; every stage is a register with its own
//   valid bit, so a new word enters on every cycle that s_axis_tready is high.
// The CORDIC is unrolled, one micro-rotation per stage, shared between the
//   vectoring (rect->polar) and rotation (polar->rect) modes.
// Stall: when m_axis_tready is low and a result waits, the whole pipe holds
//   and s_axis_tready drops; nothing is lost or repeated. Bubbles advance
//   freely while the output register is empty.
// Reset: rst_n clears all valid bits; the data registers are not reset, but no words
//   are in flight afterwards and the unit is ready at once.
`default_nettype none
module vector_rect_polar_unit
    import vrp_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // arg_a, arg_b, arg_c, arg_d
    input  wire logic [2:0]   s_axis_tuser,  // op
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,  // x_out, y_out, magnitude, angle_deg, pad
    output logic [1:0]        m_axis_tuser   // status
);

    localparam int STEPS_EFF = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    logic               en;
    logic               out_valid;
    logic signed [31:0] x_out, y_out;
    logic [31:0]        magnitude;
    logic signed [24:0] angle_deg;
    logic [1:0]         status;

    cvec_t cv [STEPS_EFF+1];
    side_t sd [STEPS_EFF+1];
    logic  vl [STEPS_EFF+1];

    // advance the whole pipe unless a finished word is stuck at the output
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    vrp_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .op        (s_axis_tuser),
        .arg_a     (signed'(s_axis_tdata[31:0])),
        .arg_b     (signed'(s_axis_tdata[63:32])),
        .arg_c     (signed'(s_axis_tdata[95:64])),
        .arg_d     (signed'(s_axis_tdata[127:96])),
        .out_valid (vl[0]),
        .out_vec   (cv[0]),
        .out_side  (sd[0])
    );

    // one micro-rotation per stage
    for (genvar i = 0; i < STEPS_EFF; i++)
    begin : g_cordic
        vrp_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vl[i]),
            .in_vec    (cv[i]),
            .in_side   (sd[i]),
            .out_valid (vl[i+1]),
            .out_vec   (cv[i+1]),
            .out_side  (sd[i+1])
        );
    end

    vrp_post #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vl[STEPS_EFF]),
        .in_vec    (cv[STEPS_EFF]),
        .in_side   (sd[STEPS_EFF]),
        .out_valid (out_valid),
        .x_out     (x_out),
        .y_out     (y_out),
        .magnitude (magnitude),
        .angle_deg (angle_deg),
        .status    (status)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {7'd0, angle_deg, magnitude, y_out, x_out};
    assign m_axis_tuser  = status;

endmodule
`default_nettype wire

[rtl/vrp_checker.sv]
`default_nettype none
`include "vector_rect_polar_unit_defines.svh"
module vrp_assertions
    import vrp_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser
);

    `VRP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")
    `VRP_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input blocked while output is empty")
    `VRP_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == ST_OK || m_axis_tuser == ST_INVALID || m_axis_tuser == ST_SAT, "undefined status code")
    `VRP_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && m_axis_tuser == ST_INVALID, m_axis_tdata == 128'd0, "bad op word is not the zero vector")

endmodule

bind vector_rect_polar_unit vrp_assertions u_vrp_assertions (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
